>>> hw/rtl/pdfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfp_pkg
// shared types and codes for the patch dictionary field parser
// ----------------------------------------------------------------------------
package pdfp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EXTRA_CHANNELS = 2'd2;

    // result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_ERROR    = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_RESTART  = 2'd3;

    // request command codes
    localparam logic CMD_CONSUME = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // one result item
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  next_context;
        logic [7:0]  channel_number;
        logic [25:0] target_number;
        logic [23:0] ref_number;
        logic [33:0] field_value;
        logic [3:0]  field_kind;
    } t_result;

endpackage

>>> hw/rtl/pdfp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfp_cfg
// configuration registers and the reference limit min(w*h/16, cap)
// ----------------------------------------------------------------------------
module pdfp_cfg #(
    parameter int MAX_REFS_CAP = 16777216,
    parameter int LIM_W        = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic [1:0]       i_cfg_addr,
    input  logic [29:0]      i_cfg_wdata,
    output logic [LIM_W-1:0] o_lim,
    output logic [7:0]       o_ext_ch,
    output logic             o_busy
);

    localparam logic [59:0] SAT_AT = 60'(MAX_REFS_CAP) << 4;

    logic [29:0]      r_width;
    logic [29:0]      r_height;
    logic [7:0]       r_ext_ch;
    logic [44:0]      r_pp_lo;
    logic [44:0]      r_pp_hi;
    logic [LIM_W-1:0] r_lim;
    logic [1:0]       r_settle;
    logic [59:0]      area;

    // two 30x15 partial products, then one add and saturate
    assign area = {15'd0, r_pp_lo} + {r_pp_hi, 15'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 30'd1;
            r_height <= 30'd1;
            r_ext_ch <= 8'd0;
            r_settle <= 2'd2;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_addr)
                    pdfp_pkg::CFG_FRAME_WIDTH:    r_width  <= i_cfg_wdata;
                    pdfp_pkg::CFG_FRAME_HEIGHT:   r_height <= i_cfg_wdata;
                    pdfp_pkg::CFG_EXTRA_CHANNELS: r_ext_ch <= i_cfg_wdata[7:0];
                    default: ;
                endcase
                r_settle <= 2'd2;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp_lo <= 45'(r_width * r_height[14:0]);
        r_pp_hi <= 45'(r_width * r_height[29:15]);
        if (area >= SAT_AT) begin
            r_lim <= LIM_W'(MAX_REFS_CAP);
        end else begin
            r_lim <= area[4 +: LIM_W];
        end
    end

    assign o_lim    = r_lim;
    assign o_ext_ch = r_ext_ch;
    assign o_busy   = (r_settle != 2'd0);

endmodule

>>> hw/rtl/pdfp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfp_step
// grammar state and the combinational step for one decoded value
// ----------------------------------------------------------------------------
module pdfp_step #(
    parameter int LIM_W = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_command,
    input  logic [31:0]       i_value,
    input  logic [LIM_W-1:0]  i_lim,
    input  logic [7:0]        i_ext_ch,
    output pdfp_pkg::t_result o_res
);

    localparam logic [3:0] PH_REFCOUNT = 4'd0;
    localparam logic [3:0] PH_SLOT     = 4'd1;
    localparam logic [3:0] PH_X0       = 4'd2;
    localparam logic [3:0] PH_Y0       = 4'd3;
    localparam logic [3:0] PH_W        = 4'd4;
    localparam logic [3:0] PH_H        = 4'd5;
    localparam logic [3:0] PH_COUNT    = 4'd6;
    localparam logic [3:0] PH_TX       = 4'd7;
    localparam logic [3:0] PH_TY       = 4'd8;
    localparam logic [3:0] PH_MODE     = 4'd9;
    localparam logic [3:0] PH_ALPHA    = 4'd10;
    localparam logic [3:0] PH_CLAMP    = 4'd11;
    localparam logic [3:0] PH_DONE     = 4'd12;

    localparam logic [3:0] CTX_NONE   = 4'd0;
    localparam logic [3:0] CTX_SLOT   = 4'd1;
    localparam logic [3:0] CTX_SIZE   = 4'd2;
    localparam logic [3:0] CTX_ORIGIN = 4'd3;
    localparam logic [3:0] CTX_FIRST  = 4'd4;
    localparam logic [3:0] CTX_MODE   = 4'd5;
    localparam logic [3:0] CTX_DELTA  = 4'd6;
    localparam logic [3:0] CTX_COUNT  = 4'd7;
    localparam logic [3:0] CTX_ALPHA  = 4'd8;
    localparam logic [3:0] CTX_CLAMP  = 4'd9;

    logic [3:0]       r_phase,         n_phase;
    logic [LIM_W-1:0] r_refs_total,    n_refs_total;
    logic [LIM_W-1:0] r_ref_index,     n_ref_index;
    logic [32:0]      r_targets_total, n_targets_total;
    logic [32:0]      r_target_index,  n_target_index;
    logic [8:0]       r_channel_index, n_channel_index;
    logic [33:0]      r_patch_sum,     n_patch_sum;
    logic [31:0]      r_last_x,        n_last_x;
    logic [31:0]      r_last_y,        n_last_y;
    logic             r_have_last,     n_have_last;
    logic             r_error_seen,    n_error_seen;

    logic [33:0]      new_sum;
    logic [33:0]      lim4;
    logic [31:0]      held;
    logic [31:0]      unz;
    logic [32:0]      coord_sum;
    logic [8:0]       ci1;
    logic [32:0]      ti1;
    logic [LIM_W-1:0] ri1;
    logic             err;
    logic             done;
    logic             nc;
    logic [33:0]      fv;

    function automatic logic [3:0] f_context(input logic [3:0] ph, input logic hl);
        logic [3:0] c;
        c = CTX_NONE;
        unique case (ph)
            PH_SLOT:         c = CTX_SLOT;
            PH_X0, PH_Y0:    c = CTX_ORIGIN;
            PH_W, PH_H:      c = CTX_SIZE;
            PH_COUNT:        c = CTX_COUNT;
            PH_TX, PH_TY:    c = hl ? CTX_DELTA : CTX_FIRST;
            PH_MODE:         c = CTX_MODE;
            PH_ALPHA:        c = CTX_ALPHA;
            PH_CLAMP:        c = CTX_CLAMP;
            default:         c = CTX_NONE;
        endcase
        return c;
    endfunction

    assign new_sum   = r_patch_sum + 34'(i_value) + 34'd1;
    assign lim4      = 34'(i_lim) << 2;
    assign held      = (r_phase == PH_TX) ? r_last_x : r_last_y;
    // zigzag decode: odd codes are negative
    assign unz       = i_value[0] ? {1'b1, ~i_value[31:1]} : {1'b0, i_value[31:1]};
    assign coord_sum = {held[31], held} + {unz[31], unz};
    assign ci1       = r_channel_index + 9'd1;
    assign ti1       = r_target_index + 33'd1;
    assign ri1       = r_ref_index + LIM_W'(1);

    always_comb begin
        n_phase         = r_phase;
        n_refs_total    = r_refs_total;
        n_ref_index     = r_ref_index;
        n_targets_total = r_targets_total;
        n_target_index  = r_target_index;
        n_channel_index = r_channel_index;
        n_patch_sum     = r_patch_sum;
        n_last_x        = r_last_x;
        n_last_y        = r_last_y;
        n_have_last     = r_have_last;
        n_error_seen    = r_error_seen;
        err             = 1'b0;
        done            = 1'b0;
        nc              = 1'b0;
        fv              = '0;

        o_res                = '0;
        o_res.ref_number     = 24'(r_ref_index);
        o_res.target_number  = r_target_index[25:0];
        o_res.channel_number = r_channel_index[7:0];

        if (i_command == pdfp_pkg::CMD_RESTART) begin
            n_phase         = PH_REFCOUNT;
            n_refs_total    = '0;
            n_ref_index     = '0;
            n_targets_total = '0;
            n_target_index  = '0;
            n_channel_index = '0;
            n_patch_sum     = '0;
            n_last_x        = '0;
            n_last_y        = '0;
            n_have_last     = 1'b0;
            n_error_seen    = 1'b0;
            o_res           = '0;
            o_res.status    = pdfp_pkg::ST_RESTART;
        end else if (r_error_seen) begin
            o_res.field_kind = r_phase;
            o_res.status     = pdfp_pkg::ST_ERROR;
        end else if (r_phase == PH_DONE) begin
            o_res.status = pdfp_pkg::ST_COMPLETE;
        end else begin
            unique case (r_phase)
                PH_REFCOUNT: begin
                    fv = 34'(i_value);
                    if (i_value > 32'(i_lim)) begin
                        err = 1'b1;
                    end else if (i_value == 32'd0) begin
                        n_phase = PH_DONE;
                        done    = 1'b1;
                    end else begin
                        n_refs_total = i_value[LIM_W-1:0];
                        n_ref_index  = '0;
                        n_patch_sum  = '0;
                        n_phase      = PH_SLOT;
                    end
                end
                PH_SLOT: begin
                    fv = 34'(i_value);
                    if (i_value >= 32'd4) err = 1'b1;
                    else n_phase = PH_X0;
                end
                PH_X0: begin
                    fv      = 34'(i_value);
                    n_phase = PH_Y0;
                end
                PH_Y0: begin
                    fv      = 34'(i_value);
                    n_phase = PH_W;
                end
                PH_W: begin
                    fv      = 34'(i_value) + 34'd1;
                    n_phase = PH_H;
                end
                PH_H: begin
                    fv      = 34'(i_value) + 34'd1;
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    fv          = 34'(i_value) + 34'd1;
                    n_patch_sum = new_sum;
                    if (new_sum > lim4) begin
                        err = 1'b1;
                    end else begin
                        n_targets_total = 33'(i_value) + 33'd1;
                        n_target_index  = '0;
                        n_have_last     = 1'b0;
                        n_phase         = PH_TX;
                    end
                end
                PH_TX, PH_TY: begin
                    fv = r_have_last ? {coord_sum[32], coord_sum} : {{2{i_value[31]}}, i_value};
                    if (r_have_last && (coord_sum[32] != coord_sum[31])) begin
                        err = 1'b1;
                    end else if (r_phase == PH_TX) begin
                        n_last_x = fv[31:0];
                        n_phase  = PH_TY;
                    end else begin
                        n_last_y        = fv[31:0];
                        n_have_last     = 1'b1;
                        n_channel_index = '0;
                        n_phase         = PH_MODE;
                    end
                end
                PH_MODE: begin
                    fv = 34'(i_value);
                    if (i_value > 32'd7) begin
                        err = 1'b1;
                    end else if (i_value >= 32'd4 && i_ext_ch == 8'd0) begin
                        // alpha blend needs an extra channel
                        err = 1'b1;
                    end else if (i_value >= 32'd4 && i_ext_ch >= 8'd2) begin
                        n_phase = PH_ALPHA;
                    end else if (i_value >= 32'd3) begin
                        n_phase = PH_CLAMP;
                    end else begin
                        nc = 1'b1;
                    end
                end
                PH_ALPHA: begin
                    fv = 34'(i_value);
                    if (i_value >= 32'(i_ext_ch)) err = 1'b1;
                    else n_phase = PH_CLAMP;
                end
                PH_CLAMP: begin
                    fv = (i_value != 32'd0) ? 34'd1 : 34'd0;
                    nc = 1'b1;
                end
                default: ;
            endcase

            // step to next channel, target or reference
            if (nc) begin
                n_channel_index = ci1;
                if (ci1 < ({1'b0, i_ext_ch} + 9'd1)) begin
                    n_phase = PH_MODE;
                end else begin
                    n_target_index = ti1;
                    if (ti1 < r_targets_total) begin
                        n_phase = PH_TX;
                    end else begin
                        n_ref_index = ri1;
                        if (ri1 < r_refs_total) begin
                            n_phase = PH_SLOT;
                        end else begin
                            n_phase = PH_DONE;
                            done    = 1'b1;
                        end
                    end
                end
            end

            if (err) begin
                n_phase      = r_phase;
                n_error_seen = 1'b1;
            end

            o_res.field_kind   = r_phase;
            o_res.field_value  = fv;
            o_res.next_context = (err || done) ? CTX_NONE : f_context(n_phase, n_have_last);
            o_res.status       = err ? pdfp_pkg::ST_ERROR :
                                 done ? pdfp_pkg::ST_COMPLETE : pdfp_pkg::ST_ACCEPTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_REFCOUNT;
            r_refs_total    <= '0;
            r_ref_index     <= '0;
            r_targets_total <= '0;
            r_target_index  <= '0;
            r_channel_index <= '0;
            r_patch_sum     <= '0;
            r_last_x        <= '0;
            r_last_y        <= '0;
            r_have_last     <= 1'b0;
            r_error_seen    <= 1'b0;
        end else if (i_adv) begin
            r_phase         <= n_phase;
            r_refs_total    <= n_refs_total;
            r_ref_index     <= n_ref_index;
            r_targets_total <= n_targets_total;
            r_target_index  <= n_target_index;
            r_channel_index <= n_channel_index;
            r_patch_sum     <= n_patch_sum;
            r_last_x        <= n_last_x;
            r_last_y        <= n_last_y;
            r_have_last     <= n_have_last;
            r_error_seen    <= n_error_seen;
        end
    end

endmodule

>>> hw/rtl/patch_dictionary_field_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_dictionary_field_parser_core
// walks the patch dictionary grammar, one entropy-decoded value per request
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one decoded value (tdata) and a
// command bit (tuser: 0 consume, 1 restart). The block answers every request
// with exactly one result: the reconstructed field, its reference, target and
// channel indices, the entropy context for the next value and a status
// (accepted, error, complete, restarted). Throughput is one request per clock
// unless the result stream stalls or configuration settles. A request passes
// the input register, the grammar step, then the result register. Errors latch
// until a restart. After a configuration write the slave tready drops while the
// frame-area product settles through its two-stage 30x15 multiply and saturate.
// The user must write configuration only when idle; it is not enforced.
// ----------------------------------------------------------------------------
module patch_dictionary_field_parser_core #(
    parameter int MAX_REFS_CAP = 16777216
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_addr,
    input  logic [29:0] i_cfg_wdata,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tuser,   // [0] command
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // [33:0] field_value, [57:34] ref_number,
                                     // [83:58] target_number, [91:84] channel_number,
                                     // [95:92] next_context
    output logic [5:0]  o_m_tuser    // [3:0] field_kind, [5:4] status
);

    localparam int LIM_W = $clog2(MAX_REFS_CAP + 1);

    logic              r_in_valid;
    logic              r_in_cmd;
    logic [31:0]       r_in_value;
    logic              r_out_valid;
    pdfp_pkg::t_result r_out;
    pdfp_pkg::t_result res;
    logic [LIM_W-1:0]  lim;
    logic [7:0]        ext_ch;
    logic              cfg_busy;
    logic              s_accept;
    logic              adv;

    // a held request moves on when the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !cfg_busy && (!r_in_valid || adv);
    assign s_accept   = i_s_tvalid && o_s_tready;

    pdfp_cfg #(
        .MAX_REFS_CAP (MAX_REFS_CAP),
        .LIM_W        (LIM_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_lim       (lim),
        .o_ext_ch    (ext_ch),
        .o_busy      (cfg_busy)
    );

    pdfp_step #(
        .LIM_W (LIM_W)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_command (r_in_cmd),
        .i_value   (r_in_value),
        .i_lim     (lim),
        .i_ext_ch  (ext_ch),
        .o_res     (res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) r_in_valid <= 1'b1;
            else if (adv) r_in_valid <= 1'b0;

            if (adv)             r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_cmd   <= i_s_tuser;
            r_in_value <= i_s_tdata;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.next_context, r_out.channel_number, r_out.target_number,
                         r_out.ref_number, r_out.field_value};
    assign o_m_tuser  = {r_out.status, r_out.field_kind};

endmodule

>>> hw/rtl/pdfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfp_checker
// port-level checks on the patch dictionary field parser
// ----------------------------------------------------------------------------
module pdfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_wen,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [95:0] o_m_tdata,
    input logic [5:0]  o_m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // requests held off while the reference limit settles
    a_cfg_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wen |=> !o_s_tready)
        else $error("request taken right after a configuration write");

    // a restart reports an all-zero field
    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[5:4] == pdfp_pkg::ST_RESTART |->
            o_m_tdata == 96'd0 && o_m_tuser[3:0] == 4'd0)
        else $error("restart result carries data");

    // no next context once parsing has stopped
    a_stop_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[5:4] == pdfp_pkg::ST_ERROR ||
                       o_m_tuser[5:4] == pdfp_pkg::ST_COMPLETE) |->
            o_m_tdata[95:92] == 4'd0)
        else $error("context given after error or completion");

endmodule

bind patch_dictionary_field_parser_core pdfp_checker u_pdfp_checker (.*);
